/* rtl/core/xxh32_pkg.sv */
package xxh32_pkg;

   localparam logic [31:0] PRIME_A = 32'd2654435761;
   localparam logic [31:0] PRIME_B = 32'd2246822519;
   localparam logic [31:0] PRIME_C = 32'd3266489917;
   localparam logic [31:0] PRIME_D = 32'd668265263;
   localparam logic [31:0] PRIME_E = 32'd374761393;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LANE_MUL,
      ST_LANE_ROT,
      ST_LANE_END,
      ST_MERGE,
      ST_WORD_MUL,
      ST_WORD_ROT,
      ST_BYTE_MUL,
      ST_BYTE_ROT,
      ST_AVA_B,
      ST_AVA_C,
      ST_AVA_END,
      ST_DONE
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} << n;
      return d[63:32];
   endfunction

endpackage

/* rtl/core/xxh32_mul.sv */
module xxh32_mul (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [31:0] product
);

   logic [31:0] full;
   logic [31:0] product_ff;

   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= full;
   end

   assign product = product_ff;

endmodule

/* rtl/core/xxhash32_stream_hasher_core.sv */
// xxhash32 over a byte stream, one shared 32x32 multiplier
//
// req channel: one item per byte (req_data_byte with req_byte_present),
// req_last closes the message; an item with neither bit does nothing.
// a byteless item with req_last ends the message (empty if no byte came).
// rsp channel: one item carrying rsp_hash_value per item marked last.
// csr channel: writes the seed, sampled when a message starts.
// a plain byte only goes into the buffer, so bytes can follow back to back;
// the byte that fills a stripe runs two multiplier passes per lane, four
// lanes in turn, then ST_LANE_END stores the last lane. a last item then
// runs the merge, multiply, rotate and scale per leftover word and byte,
// then the avalanche mix before rsp_valid rises (the empty message goes
// straight to the mix). the multiplier result is registered for the next state.
// reset clears the seed, the message state and any pending result.
// while rsp_ready is low the result holds and req_ready stays low; a
// waiting result blocks the next item until it is taken.
module xxhash32_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_seed
);

   xxh32_pkg::state_type state_ff, state_in;
   logic [31:0] seed_ff;
   logic [31:0] lane_ff [4];
   logic [7:0]  buf_ff [16];
   logic [3:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in;
   logic        in_msg_ff, in_msg_in;
   logic        seen_ff, seen_in;
   logic [1:0]  lane_idx_ff, lane_idx_in;
   logic [3:0]  pos_ff, pos_in;
   logic [31:0] h_ff, h_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] res_ff, res_in;

   logic [31:0] mul_a, mul_b, mul_p;
   logic [31:0] lane_word, tail_word, acc_sum;
   logic        go, byte_go;
   logic [31:0] st0, st1, st2, st3;
   logic [3:0]  wpos;

   xxh32_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .product(mul_p));

   assign go = req_valid && req_ready;
   assign byte_go = go && req_byte_present;
   assign req_ready = (state_ff == xxh32_pkg::ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash_value = res_ff;

   assign wpos = {lane_idx_ff, 2'b00};
   assign lane_word = {buf_ff[wpos + 4'd3], buf_ff[wpos + 4'd2],
                       buf_ff[wpos + 4'd1], buf_ff[wpos]};
   assign tail_word = {buf_ff[pos_ff + 4'd3], buf_ff[pos_ff + 4'd2],
                       buf_ff[pos_ff + 4'd1], buf_ff[pos_ff]};
   assign acc_sum = lane_ff[lane_idx_ff] + mul_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xxh32_pkg::ST_IDLE;
         seed_ff <= '0;
         fill_ff <= '0;
         len_ff <= '0;
         in_msg_ff <= 1'b0;
         seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lane_idx_ff <= '0;
         pos_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            seed_ff <= csr_seed;
         end
         fill_ff <= fill_in;
         len_ff <= len_in;
         in_msg_ff <= in_msg_in;
         seen_ff <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         lane_idx_ff <= lane_idx_in;
         pos_ff <= pos_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      res_ff <= res_in;
      if (byte_go) begin
         buf_ff[fill_ff] <= req_data_byte;
      end
      if (go && !in_msg_ff) begin
         lane_ff[0] <= seed_ff + xxh32_pkg::PRIME_A + xxh32_pkg::PRIME_B;
         lane_ff[1] <= seed_ff + xxh32_pkg::PRIME_B;
         lane_ff[2] <= seed_ff;
         lane_ff[3] <= seed_ff - xxh32_pkg::PRIME_A;
      end else if ((state_ff == xxh32_pkg::ST_LANE_MUL && lane_idx_ff != 2'd0) ||
                   state_ff == xxh32_pkg::ST_LANE_END) begin
         lane_ff[lane_idx_ff - 2'd1] <= mul_p;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      in_msg_in = in_msg_ff;
      seen_in = seen_ff;
      rsp_valid_in = rsp_valid_ff;
      lane_idx_in = lane_idx_ff;
      pos_in = pos_ff;
      last_in = last_ff;
      h_in = h_ff;
      res_in = res_ff;
      mul_a = '0;
      mul_b = '0;
      st0 = xxh32_pkg::rotl(lane_ff[0], 5'd1);
      st1 = xxh32_pkg::rotl(lane_ff[1], 5'd7);
      st2 = xxh32_pkg::rotl(lane_ff[2], 5'd12);
      st3 = xxh32_pkg::rotl(lane_ff[3], 5'd18);
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         xxh32_pkg::ST_IDLE: begin
            if (go && (req_byte_present || req_last)) begin
               last_in = req_last;
               if (!in_msg_ff) begin
                  in_msg_in = 1'b1;
                  seen_in = 1'b0;
                  fill_in = '0;
                  len_in = '0;
               end
               if (req_byte_present) begin
                  len_in = (in_msg_ff ? len_ff : 32'd0) + 32'd1;
                  fill_in = (in_msg_ff ? fill_ff : 4'd0) + 4'd1;
                  if (in_msg_ff && fill_ff == 4'd15) begin
                     lane_idx_in = '0;
                     state_in = xxh32_pkg::ST_LANE_MUL;
                     seen_in = 1'b1;
                  end else if (req_last) begin
                     state_in = xxh32_pkg::ST_MERGE;
                  end
               end else begin
                  state_in = xxh32_pkg::ST_MERGE;
               end
            end
         end
         xxh32_pkg::ST_LANE_MUL: begin
            // word times prime b; the previous lane takes its product
            mul_a = lane_word;
            mul_b = xxh32_pkg::PRIME_B;
            state_in = xxh32_pkg::ST_LANE_ROT;
         end
         xxh32_pkg::ST_LANE_ROT: begin
            mul_a = xxh32_pkg::rotl(acc_sum, 5'd13);
            mul_b = xxh32_pkg::PRIME_A;
            state_in = xxh32_pkg::ST_LANE_MUL;
         end
         xxh32_pkg::ST_LANE_END: begin
            state_in = last_ff ? xxh32_pkg::ST_MERGE : xxh32_pkg::ST_IDLE;
         end
         xxh32_pkg::ST_MERGE: begin
            h_in = (seen_ff ? (st0 + st1 + st2 + st3) : (lane_ff[2] + xxh32_pkg::PRIME_E))
                   + len_ff;
            pos_in = '0;
            state_in = (fill_ff >= 4'd4) ? xxh32_pkg::ST_WORD_MUL :
                       (fill_ff != 4'd0) ? xxh32_pkg::ST_BYTE_MUL : xxh32_pkg::ST_AVA_B;
         end
         xxh32_pkg::ST_WORD_MUL: begin
            mul_a = tail_word;
            mul_b = xxh32_pkg::PRIME_C;
            state_in = xxh32_pkg::ST_WORD_ROT;
         end
         xxh32_pkg::ST_WORD_ROT: begin
            h_in = h_ff + mul_p;
            state_in = xxh32_pkg::ST_DONE;
            h_in = xxh32_pkg::rotl(h_in, 5'd17);
            // reuse done state as a multiply-by-prime d slot
            pos_in = pos_ff + 4'd4;
         end
         xxh32_pkg::ST_BYTE_MUL: begin
            mul_a = {24'd0, buf_ff[pos_ff]};
            mul_b = xxh32_pkg::PRIME_E;
            state_in = xxh32_pkg::ST_BYTE_ROT;
         end
         xxh32_pkg::ST_BYTE_ROT: begin
            h_in = xxh32_pkg::rotl(h_ff + mul_p, 5'd11);
            pos_in = pos_ff + 4'd1;
            state_in = xxh32_pkg::ST_DONE;
         end
         xxh32_pkg::ST_DONE: begin
            // scale by prime d after a word, prime a after a byte
            mul_a = h_ff;
            mul_b = (pos_ff <= (fill_ff & 4'hc)) ? xxh32_pkg::PRIME_D : xxh32_pkg::PRIME_A;
            state_in = xxh32_pkg::ST_AVA_END;
            last_in = 1'b0;
            lane_idx_in = 2'd1;
         end
         xxh32_pkg::ST_AVA_END: begin
            if (lane_idx_ff == 2'd1) begin
               h_in = mul_p;
               lane_idx_in = '0;
               state_in = ({1'b0, pos_ff} + 5'd4 <= {1'b0, fill_ff}) ?
                          xxh32_pkg::ST_WORD_MUL :
                          (pos_ff < fill_ff) ? xxh32_pkg::ST_BYTE_MUL : xxh32_pkg::ST_AVA_B;
            end else begin
               res_in = mul_p ^ (mul_p >> 16);
               rsp_valid_in = 1'b1;
               fill_in = '0;
               len_in = '0;
               seen_in = 1'b0;
               in_msg_in = 1'b0;
               state_in = xxh32_pkg::ST_IDLE;
            end
         end
         xxh32_pkg::ST_AVA_B: begin
            mul_a = h_ff ^ (h_ff >> 15);
            mul_b = xxh32_pkg::PRIME_B;
            state_in = xxh32_pkg::ST_AVA_C;
         end
         xxh32_pkg::ST_AVA_C: begin
            mul_a = mul_p ^ (mul_p >> 13);
            mul_b = xxh32_pkg::PRIME_C;
            lane_idx_in = '0;
            state_in = xxh32_pkg::ST_AVA_END;
         end
         default: state_in = xxh32_pkg::ST_IDLE;
      endcase
      if (state_ff == xxh32_pkg::ST_LANE_ROT) begin
         if (lane_idx_ff == 2'd3) begin
            fill_in = '0;
            state_in = xxh32_pkg::ST_LANE_END;
         end
         lane_idx_in = lane_idx_ff + 2'd1;
      end
   end

endmodule

/* rtl/core/xxh32_checker.sv */
module xxh32_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result dropped while stalled");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item taken with result pending");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("item withdrawn before accept");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind xxhash32_stream_hasher_core xxh32_checker u_xxh32_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hash_value(rsp_hash_value)
);

/* bench/tb_top.sv */
module tb_top;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_byte_present = 1'b0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash_value;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_seed = 32'd0;

   byte_item_type pending_bytes[$];
   logic [31:0] expected_hashes[$];
   int          mismatches = 0;
   int          hashes_checked = 0;
   int          bytes_sent = 0;
   int          stall_cycles = 0;
   bit          calm_phase = 1'b0;
   bit          sender_hold = 1'b0;

   // predictor state
   logic [31:0] hs_seed;
   logic [31:0] hs_lane[4];
   logic [7:0]  hs_stripe[16];
   int          hs_fill;
   logic [31:0] hs_length;
   bit          hs_active;
   bit          hs_stripe_seen;

   xxhash32_stream_hasher_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_byte_present(req_byte_present),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hash_value(rsp_hash_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_seed(csr_seed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
      return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
   endfunction

   function automatic logic [31:0] stripe_word(input int pos);
      return {hs_stripe[pos + 3], hs_stripe[pos + 2], hs_stripe[pos + 1], hs_stripe[pos]};
   endfunction

   function automatic logic [31:0] lane_mix(input logic [31:0] acc, input logic [31:0] w);
      return rot32(acc + w * xxh32_pkg::PRIME_B, 13) * xxh32_pkg::PRIME_A;
   endfunction

   function automatic logic [31:0] final_hash();
      logic [31:0] h;
      int pos;
      pos = 0;
      if (hs_stripe_seen) begin
         h = rot32(hs_lane[0], 1) + rot32(hs_lane[1], 7) + rot32(hs_lane[2], 12)
            + rot32(hs_lane[3], 18);
      end else begin
         h = hs_lane[2] + xxh32_pkg::PRIME_E;
      end
      h = h + hs_length;
      while (pos + 4 <= hs_fill) begin
         h = rot32(h + stripe_word(pos) * xxh32_pkg::PRIME_C, 17) * xxh32_pkg::PRIME_D;
         pos += 4;
      end
      while (pos < hs_fill) begin
         h = rot32(h + {24'd0, hs_stripe[pos]} * xxh32_pkg::PRIME_E, 11) * xxh32_pkg::PRIME_A;
         pos++;
      end
      h = h ^ (h >> 15);
      h = h * xxh32_pkg::PRIME_B;
      h = h ^ (h >> 13);
      h = h * xxh32_pkg::PRIME_C;
      h = h ^ (h >> 16);
      return h;
   endfunction

   task automatic predict_hash(input byte_item_type it);
      if (!it.byte_present && !it.last) return;
      if (!hs_active) begin
         hs_lane[0] = hs_seed + xxh32_pkg::PRIME_A + xxh32_pkg::PRIME_B;
         hs_lane[1] = hs_seed + xxh32_pkg::PRIME_B;
         hs_lane[2] = hs_seed;
         hs_lane[3] = hs_seed - xxh32_pkg::PRIME_A;
         hs_fill = 0;
         hs_length = 0;
         hs_stripe_seen = 0;
         hs_active = 1;
      end
      if (it.byte_present) begin
         hs_stripe[hs_fill] = it.data_byte;
         hs_fill++;
         hs_length++;
         if (hs_fill == 16) begin
            for (int i = 0; i < 4; i++) hs_lane[i] = lane_mix(hs_lane[i], stripe_word(4 * i));
            hs_fill = 0;
            hs_stripe_seen = 1;
         end
      end
      if (it.last) begin
         expected_hashes.push_back(final_hash());
         hs_fill = 0;
         hs_length = 0;
         hs_stripe_seen = 0;
         hs_active = 0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) bytes_sent++;
         if (pending_bytes.size() > 0 && !sender_hold
             && (calm_phase || $urandom_range(99) >= 28)) begin
            byte_item_type it;
            it = pending_bytes.pop_front();
            predict_hash(it);
            req_valid <= 1'b1;
            req_data_byte <= it.data_byte;
            req_byte_present <= it.byte_present;
            req_last <= it.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t unexpected hash: expected none, actual %h", $time, rsp_hash_value);
               mismatches++;
            end else begin
               logic [31:0] want;
               want = expected_hashes.pop_front();
               if (want !== rsp_hash_value) begin
                  $display("%0t hash_value: expected %h, actual %h", $time, want,
                           rsp_hash_value);
                  mismatches++;
               end
               hashes_checked++;
            end
         end
         if (stall_cycles > 0) begin
            stall_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_phase || ($urandom_range(99) >= 28);
         end
      end
   end

   task automatic queue_message(input int len, input bit empty_tail);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            it = '{data_byte: 8'($urandom), byte_present: 1'b0, last: 1'b0};
            pending_bytes.push_back(it);
         end
         it.data_byte = 8'($urandom);
         it.byte_present = 1'b1;
         it.last = (i == len - 1) && !empty_tail;
         pending_bytes.push_back(it);
      end
      if (empty_tail || len == 0) begin
         it = '{data_byte: 8'($urandom), byte_present: 1'b0, last: 1'b1};
         pending_bytes.push_back(it);
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_valid || expected_hashes.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_seed <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      hs_seed = value;
   endtask

   initial begin
      logic [31:0] seeds[5];
      int len;
      seeds = '{32'd0, 32'hFFFF_FFFF, 32'h9E37_79B1, 32'h0000_0001, 32'h8000_0000};
      hs_seed = 0;
      hs_active = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset seed
      queue_message(0, 1'b1);
      pending_bytes.push_back('{data_byte: 8'hFF, byte_present: 1'b1, last: 1'b1});
      pending_bytes.push_back('{data_byte: 8'h00, byte_present: 1'b1, last: 1'b1});
      queue_message(3, 1'b1);
      queue_message(16, 1'b0);
      wait_drained();

      // seed change mid-message has no effect
      pending_bytes.push_back('{data_byte: 8'hA5, byte_present: 1'b1, last: 1'b0});
      wait_drained();
      write_seed(32'h1234_5678);
      pending_bytes.push_back('{data_byte: 8'h5A, byte_present: 1'b1, last: 1'b1});
      wait_drained();

      for (int s = 0; s < 5; s++) begin
         write_seed(seeds[s]);
         calm_phase = (s == 2);
         for (int m = 0; m < 6; m++) begin
            case ($urandom_range(3))
               0: len = $urandom_range(15);
               1: len = 16 * $urandom_range(1, 2);
               2: len = $urandom_range(17, 40);
               default: len = $urandom_range(60);
            endcase
            queue_message(len, $urandom_range(4) == 0);
         end
         if (s == 1) begin
            stall_cycles = 300;
         end
         wait_drained();
         if (s == 3) begin
            sender_hold = 1'b1;
            queue_message(20, 1'b0);
            repeat (5) @(posedge clock);
            sender_hold = 1'b0;
            wait_drained();
         end
      end
      calm_phase = 1'b0;

      $display("covered %0d items, %0d hashes checked over five seeds incl. extremes",
               bytes_sent, hashes_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

/* files.f */
rtl/core/xxh32_pkg.sv
rtl/core/xxh32_mul.sv
rtl/core/xxhash32_stream_hasher_core.sv
rtl/core/xxh32_checker.sv
bench/tb_top.sv
